>>> rtl/qgi_pkg.sv
// Package for the quaternion gyro integrator: widths, reset constants, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qgi_pkg;
    localparam logic [31:0] Q_ONE = 32'h2000_0000;
    localparam logic [31:0] DT_RESET = 32'd8589935;
    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PROD  = 8'b0000_0010,
        ST_SCALE = 8'b0000_0100,
        ST_SQ    = 8'b0000_1000,
        ST_SQRT  = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_GRAV  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) begin
            return SAT_MAX;
        end else if (v < -68'sd2147483648) begin
            return SAT_MIN;
        end else begin
            return v[31:0];
        end
    endfunction
endpackage
`default_nettype wire

>>> rtl/quaternion_gyro_integrator.sv
// Quaternion gyro integrator top level: sequencer around one shared 33x33 multiplier,
// a bit-serial square root and a restoring divider. Uses qgi_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//  - s_ beat: one gyro sample. tdata = {rate_z, rate_y, rate_x} (x lowest), tuser = renormalize.
//  - m_ beat: quaternion plus body-frame gravity. tdata = {gz, gy, gx, qz, qy, qx, qw}
//    from qw up (224 bits), tuser = degenerate.
//  - cfg_ channel writes time_step (unsigned Q0.32 seconds); only write while idle.
// Sequencing
//  - One sample at a time. Without renormalise: the rate products (12 multiplies,
//    one spare slot after each of the first three components), the dt scaling and gravity.
//  - With renormalise: squares, then (unless the sum is zero) root steps and 4 divides
//    (load, 62 steps, write back) come between the dt scaling and gravity. The single
//    multiplier and the one-bit-a-step divider set how long a sample takes.
//  - s_tready is high only in idle; it rises again when the result beat is taken.
// Reset
//  - aresetn low (synchronous) sets the attitude to identity, time_step to 2 ms
//    and the sequencer to idle. No clearing pass.
// Stall
//  - The result holds in m_tdata while m_tready is low; no new sample is taken meanwhile.
module quaternion_gyro_integrator
    import qgi_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // rate_x, rate_y, rate_z
    input  wire logic         s_tuser,   // renormalize
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [223:0]      m_tdata,   // quat_w,x,y,z, gravity_x,y,z
    output logic              m_tuser    // degenerate
);
    state_t state_reg, state_next;
    logic [31:0]        dt_reg;
    logic signed [31:0] q_reg [4];       // attitude w,x,y,z
    logic signed [31:0] g_reg [3];       // latched rates
    logic               renorm_reg;
    logic signed [65:0] acc_reg [4];     // sums of halved products (Q.53)
    logic [3:0]         step_reg;
    logic [63:0]        sum_reg;
    logic               over_reg;
    // root
    logic [63:0]        rn_reg, rres_reg, rbit_reg;
    logic [5:0]         rcnt_reg;
    // divider
    logic [32:0]        rem_reg;
    logic [61:0]        quo_reg;
    logic [5:0]         dcnt_reg;
    logic [31:0]        len_reg;
    logic signed [31:0] grav_reg [3];
    logic signed [67:0] gacc_reg;
    logic               deg_reg;
    logic               mvalid_reg;

    // shared multiplier
    logic signed [32:0] ma, mb;
    logic signed [65:0] mp;
    assign mp = ma * mb;

    // product schedule: component k, term j -> (q index, g index, sign)
    logic [1:0] pk, pj;
    assign pk = step_reg[3:2];
    assign pj = step_reg[1:0];
    logic [1:0] qi, gi;
    logic       psub;
    always_comb begin
        qi = 2'd0; gi = 2'd0; psub = 1'b0;
        case ({pk, pj})
            4'h0: begin qi = 2'd1; gi = 2'd0; psub = 1'b1; end
            4'h1: begin qi = 2'd2; gi = 2'd1; psub = 1'b1; end
            4'h2: begin qi = 2'd3; gi = 2'd2; psub = 1'b1; end
            4'h4: begin qi = 2'd0; gi = 2'd0; psub = 1'b0; end
            4'h5: begin qi = 2'd2; gi = 2'd2; psub = 1'b0; end
            4'h6: begin qi = 2'd3; gi = 2'd1; psub = 1'b1; end
            4'h8: begin qi = 2'd0; gi = 2'd1; psub = 1'b0; end
            4'h9: begin qi = 2'd1; gi = 2'd2; psub = 1'b1; end
            4'hA: begin qi = 2'd3; gi = 2'd0; psub = 1'b0; end
            4'hC: begin qi = 2'd0; gi = 2'd2; psub = 1'b0; end
            4'hD: begin qi = 2'd1; gi = 2'd1; psub = 1'b0; end
            4'hE: begin qi = 2'd2; gi = 2'd0; psub = 1'b1; end
            default: begin qi = 2'd0; gi = 2'd0; psub = 1'b0; end
        endcase
    end

    // dt scaling: |S| split into halves; two multiplies per component
    logic [1:0]         sk;
    logic               sh;
    logic               sneg;
    logic [65:0]        smag;
    logic [63:0]        lo_reg;
    assign sk = step_reg[2:1];
    assign sh = step_reg[0];
    assign sneg = acc_reg[sk][65];
    assign smag = sneg ? 66'(-acc_reg[sk]) : 66'(acc_reg[sk]);

    // gravity schedule: 2 products per term
    logic [1:0] ga, gb;
    logic       gsub;
    always_comb begin
        ga = 2'd0; gb = 2'd0; gsub = 1'b0;
        case (step_reg[2:0])
            3'd0: begin ga = 2'd1; gb = 2'd3; gsub = 1'b0; end
            3'd1: begin ga = 2'd0; gb = 2'd2; gsub = 1'b1; end
            3'd2: begin ga = 2'd0; gb = 2'd1; gsub = 1'b0; end
            3'd3: begin ga = 2'd2; gb = 2'd3; gsub = 1'b0; end
            3'd4: begin ga = 2'd1; gb = 2'd1; gsub = 1'b0; end
            3'd5: begin ga = 2'd2; gb = 2'd2; gsub = 1'b0; end
            default: begin ga = 2'd0; gb = 2'd0; gsub = 1'b0; end
        endcase
    end

    always_comb begin
        ma = '0; mb = '0;
        case (state_reg)
            ST_PROD: begin
                ma = 33'(q_reg[qi]); mb = 33'(g_reg[gi]);
            end
            ST_SCALE: begin
                ma = sh ? $signed({1'b0, smag[63:32]}) : $signed({1'b0, smag[31:0]});
                mb = $signed({1'b0, dt_reg});
            end
            ST_SQ: begin
                ma = 33'(q_reg[step_reg[1:0]]); mb = 33'(q_reg[step_reg[1:0]]);
            end
            ST_GRAV: begin
                ma = 33'(q_reg[ga]); mb = 33'(q_reg[gb]);
            end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    logic signed [65:0] hp;        // halved product, floor
    assign hp = mp >>> 1;

    // scale finish
    logic [65:0] hi_sum;
    logic [41:0] rmag;
    logic signed [67:0] newc;
    assign hi_sum = 66'(mp) + 66'(lo_reg[63:32]);
    assign rmag = 42'((hi_sum + 66'd8388608) >> 24);
    assign newc = 68'(q_reg[sk]) + (sneg ? -68'(rmag) : 68'(rmag));

    // square sum
    logic [64:0] sq_add;
    assign sq_add = 65'(sum_reg) + 65'(mp[63:0]);

    // root step
    logic [63:0] rtry;
    assign rtry = rres_reg + rbit_reg;

    // divide step
    logic [1:0]  dk;
    logic        dneg;
    logic [31:0] dmag;
    logic [32:0] rem_sh;
    logic        dfit;
    logic signed [67:0] dres;
    assign dk = step_reg[1:0];
    assign dneg = q_reg[dk][31];
    assign dmag = dneg ? 32'(-q_reg[dk]) : 32'(q_reg[dk]);
    assign rem_sh = {rem_reg[31:0], quo_reg[61]};
    assign dfit = rem_sh >= 33'(len_reg);
    assign dres = dneg ? -68'(quo_reg) : 68'(quo_reg);

    // gravity finish
    logic signed [67:0] gsum;
    logic signed [67:0] gterm;
    assign gsum = gacc_reg + (gsub ? -68'(hp) : 68'(hp));
    assign gterm = 68'(sat32((gsum + 68'sd67108864) >>> 27));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_PROD;
            ST_PROD:  if (step_reg == 4'd14) state_next = ST_SCALE;
            ST_SCALE: if (step_reg == 4'd7) state_next = renorm_reg ? ST_SQ : ST_GRAV;
            ST_SQ:    if (step_reg == 4'd4) state_next = (over_reg || sum_reg != 0) ? ST_SQRT : ST_GRAV;
            ST_SQRT:  if (rcnt_reg == 6'd32) state_next = ST_DIV;
            ST_DIV:   if (step_reg == 4'd3 && dcnt_reg == 6'd62) state_next = ST_GRAV;
            ST_GRAV:  if (step_reg == 4'd5) state_next = ST_OUT;
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            dt_reg <= DT_RESET;
            q_reg[0] <= Q_ONE; q_reg[1] <= '0; q_reg[2] <= '0; q_reg[3] <= '0;
            step_reg <= '0;
            mvalid_reg <= 1'b0;
            deg_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) dt_reg <= cfg_data;
            case (state_reg)
                ST_IDLE: begin
                    step_reg <= '0;
                    if (s_tvalid) begin
                        g_reg[0] <= s_tdata[31:0];
                        g_reg[1] <= s_tdata[63:32];
                        g_reg[2] <= s_tdata[95:64];
                        renorm_reg <= s_tuser;
                        for (int i = 0; i < 4; i++) acc_reg[i] <= '0;
                        deg_reg <= 1'b0;
                    end
                end
                ST_PROD: begin
                    if (pj != 2'd3)
                        acc_reg[pk] <= psub ? acc_reg[pk] - hp : acc_reg[pk] + hp;
                    step_reg <= (step_reg == 4'd14) ? 4'd0 : step_reg + 4'd1;
                end
                ST_SCALE: begin
                    if (!sh) begin
                        lo_reg <= mp[63:0];
                    end else begin
                        q_reg[sk] <= sat32(newc);
                    end
                    step_reg <= (step_reg == 4'd7) ? 4'd0 : step_reg + 4'd1;
                    sum_reg <= '0; over_reg <= 1'b0;
                end
                ST_SQ: begin
                    if (step_reg != 4'd4) begin
                        sum_reg <= sq_add[63:0];
                        if (sq_add[64]) over_reg <= 1'b1;
                        step_reg <= step_reg + 4'd1;
                    end else begin
                        step_reg <= '0;
                        if (!over_reg && sum_reg == 0) deg_reg <= 1'b1;
                        rn_reg <= over_reg ? '1 : sum_reg;
                        rres_reg <= '0;
                        rbit_reg <= 64'h4000_0000_0000_0000;
                        rcnt_reg <= '0;
                    end
                end
                ST_SQRT: begin
                    if (rcnt_reg != 6'd32) begin
                        if (rn_reg >= rtry) begin
                            rn_reg <= rn_reg - rtry;
                            rres_reg <= (rres_reg >> 1) + rbit_reg;
                        end else begin
                            rres_reg <= rres_reg >> 1;
                        end
                        rbit_reg <= rbit_reg >> 2;
                        rcnt_reg <= rcnt_reg + 6'd1;
                    end else begin
                        len_reg <= rres_reg[31:0];
                        dcnt_reg <= 6'd63;
                    end
                end
                ST_DIV: begin
                    if (dcnt_reg == 6'd63) begin
                        // load numerator (m<<29)+len/2 into quotient shifter
                        rem_reg <= '0;
                        quo_reg <= 62'({dmag, 29'd0}) + 62'(len_reg >> 1);
                        dcnt_reg <= '0;
                    end else if (dcnt_reg != 6'd62) begin
                        rem_reg <= dfit ? rem_sh - 33'(len_reg) : rem_sh;
                        quo_reg <= {quo_reg[60:0], dfit};
                        dcnt_reg <= dcnt_reg + 6'd1;
                    end else begin
                        q_reg[dk] <= sat32(dres);
                        dcnt_reg <= 6'd63;
                        step_reg <= (step_reg == 4'd3) ? 4'd0 : step_reg + 4'd1;
                    end
                end
                ST_GRAV: begin
                    if (!step_reg[0]) begin
                        gacc_reg <= gsub ? -68'(hp) : 68'(hp);
                    end else begin
                        if (step_reg[2:1] == 2'd2)
                            grav_reg[2] <= sat32(68'(Q_ONE) - gterm);
                        else
                            grav_reg[step_reg[2:1]] <= gterm[31:0];
                    end
                    step_reg <= (step_reg == 4'd5) ? 4'd0 : step_reg + 4'd1;
                    if (step_reg == 4'd5) mvalid_reg <= 1'b1;
                end
                ST_OUT: begin
                    if (m_tready) mvalid_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // divider: remainder stays below len; numerator bits shift in from the quotient top
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata = {grav_reg[2], grav_reg[1], grav_reg[0],
                      q_reg[3], q_reg[2], q_reg[1], q_reg[0]};
    assign m_tuser = deg_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid) else $error("input ready while result pending");
    a_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> state_reg == ST_OUT) else $error("result valid outside output state");
    a_deg_renorm: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> renorm_reg) else $error("degenerate without renormalise");
endmodule
`default_nettype wire

>>> bench/quaternion_gyro_integrator_tb.sv
// Self-checking bench for quaternion_gyro_integrator: bit-exact attitude predictor,
// random stream stimulus with stalls on both sides. Depends on rtl/qgi_pkg.sv and the RTL.
`timescale 1ns / 1ps
module quaternion_gyro_integrator_tb;
    import qgi_pkg::*;

    typedef struct {
        logic signed [31:0] rx, ry, rz;
        logic               renorm;
    } gyro_sample_t;

    typedef struct {
        logic signed [31:0] qw, qx, qy, qz, gx, gy, gz;
        logic               degen;
    } attitude_beat_t;

    localparam int IDLE_LIMIT = 20000;   // beatless cycles before the watchdog fires
    localparam int SETTLE     = 400;     // worst-case latency with renormalise plus margin

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;          // rate_x, rate_y, rate_z
    logic         s_tuser = 1'b0;        // renormalize
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [223:0] m_tdata;               // quat_w,x,y,z, gravity_x,y,z
    logic         m_tuser;               // degenerate

    quaternion_gyro_integrator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // predictor state: attitude and integration step as the block should hold them
    longint        att_q[4];
    logic [31:0]   step_dt;
    gyro_sample_t  samples_pending[$];
    attitude_beat_t attitude_expected[$];
    int            send_idle_pct, recv_idle_pct;
    bit            failed = 0;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // product then arithmetic halving (floor)
    function automatic longint halved(input longint a, input longint b);
        return (a * b) >>> 1;
    endfunction

    // s * dt / 2^56, rounded half away from zero
    function automatic longint dt_scaled(input longint s, input logic [31:0] dt);
        logic        neg;
        logic [63:0] m, lo, hi, r;
        neg = s < 0;
        m   = neg ? 64'(-s) : 64'(s);
        lo  = {32'd0, m[31:0]} * {32'd0, dt};
        hi  = (m >> 32) * {32'd0, dt} + (lo >> 32);
        r   = (hi + 64'd8388608) >> 24;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] res, b;
        res = '0;
        b   = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint grav_round(input longint s);
        return clamp32((s + 64'sd67108864) >>> 27);
    endfunction

    // one first-order step; all components from the old attitude
    function automatic attitude_beat_t integrate_sample(input gyro_sample_t g);
        attitude_beat_t o;
        longint w, x, y, z, gx, gy, gz, nq[4], r;
        logic [64:0] acc;
        logic [63:0] len, m;
        w = att_q[0]; x = att_q[1]; y = att_q[2]; z = att_q[3];
        gx = longint'(g.rx); gy = longint'(g.ry); gz = longint'(g.rz);
        nq[0] = clamp32(w + dt_scaled(-halved(x, gx) - halved(y, gy) - halved(z, gz), step_dt));
        nq[1] = clamp32(x + dt_scaled(halved(w, gx) + halved(y, gz) - halved(z, gy), step_dt));
        nq[2] = clamp32(y + dt_scaled(halved(w, gy) - halved(x, gz) + halved(z, gx), step_dt));
        nq[3] = clamp32(z + dt_scaled(halved(w, gz) + halved(x, gy) - halved(y, gx), step_dt));
        o.degen = 1'b0;
        if (g.renorm) begin
            acc = '0;
            for (int i = 0; i < 4; i++) acc = acc + {1'b0, 64'(nq[i] * nq[i])};
            // sum of squares saturates at all ones
            if (acc[64]) acc = {1'b0, {64{1'b1}}};
            if (acc == 0) begin
                o.degen = 1'b1;
            end else begin
                len = root_floor(acc[63:0]);
                for (int i = 0; i < 4; i++) begin
                    m     = nq[i] < 0 ? 64'(-nq[i]) : 64'(nq[i]);
                    r     = longint'(((m << 29) + (len >> 1)) / len);
                    nq[i] = clamp32(nq[i] < 0 ? -r : r);
                end
            end
        end
        for (int i = 0; i < 4; i++) att_q[i] = nq[i];
        w = nq[0]; x = nq[1]; y = nq[2]; z = nq[3];
        o.qw = 32'(w); o.qx = 32'(x); o.qy = 32'(y); o.qz = 32'(z);
        o.gx = 32'(grav_round(halved(x, z) - halved(w, y)));
        o.gy = 32'(grav_round(halved(w, x) + halved(y, z)));
        o.gz = 32'(clamp32(longint'(Q_ONE) - grav_round(halved(x, x) + halved(y, y))));
        return o;
    endfunction

    // sender: pops the pending queue, predicts on each accepted beat
    always @(posedge aclk) begin
        gyro_sample_t nxt;
        logic         load;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                attitude_expected.push_back(integrate_sample('{$signed(s_tdata[31:0]),
                    $signed(s_tdata[63:32]), $signed(s_tdata[95:64]), s_tuser}));
            load = (!s_tvalid || s_tready) && samples_pending.size() != 0
                   && $urandom_range(99, 0) >= send_idle_pct;
            if (load) begin
                nxt = samples_pending.pop_front();
                s_tdata <= {nxt.rz, nxt.ry, nxt.rx};
                s_tuser <= nxt.renorm;
                s_tvalid <= 1'b1;
            end else if (s_tready) begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure, field-by-field compare
    always @(posedge aclk) begin
        attitude_beat_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (attitude_expected.size() == 0) begin
                    $error("result beat with nothing expected");
                    failed = 1;
                end else begin
                    e = attitude_expected.pop_front();
                    if (m_tdata[31:0] !== e.qw) begin
                        $error("quat_w exp %h got %h", e.qw, m_tdata[31:0]); failed = 1;
                    end
                    if (m_tdata[63:32] !== e.qx) begin
                        $error("quat_x exp %h got %h", e.qx, m_tdata[63:32]); failed = 1;
                    end
                    if (m_tdata[95:64] !== e.qy) begin
                        $error("quat_y exp %h got %h", e.qy, m_tdata[95:64]); failed = 1;
                    end
                    if (m_tdata[127:96] !== e.qz) begin
                        $error("quat_z exp %h got %h", e.qz, m_tdata[127:96]); failed = 1;
                    end
                    if (m_tdata[159:128] !== e.gx) begin
                        $error("gravity_x exp %h got %h", e.gx, m_tdata[159:128]); failed = 1;
                    end
                    if (m_tdata[191:160] !== e.gy) begin
                        $error("gravity_y exp %h got %h", e.gy, m_tdata[191:160]); failed = 1;
                    end
                    if (m_tdata[223:192] !== e.gz) begin
                        $error("gravity_z exp %h got %h", e.gz, m_tdata[223:192]); failed = 1;
                    end
                    if (m_tuser !== e.degen) begin
                        $error("degenerate exp %b got %b", e.degen, m_tuser); failed = 1;
                    end
                end
            end
            m_tready <= $urandom_range(99, 0) >= recv_idle_pct;
        end
    end

    // watchdog: cycles without any beat on any channel
    always @(posedge aclk) begin
        int quiet;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet = quiet + 1;
            if (quiet >= IDLE_LIMIT) begin
                $display("[quaternion_gyro_integrator] ERROR");
                $finish;
            end
        end
    end

    task automatic write_time_step(input logic [31:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        step_dt = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (samples_pending.size() != 0 || s_tvalid || attitude_expected.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic queue_sample(input longint rx, ry, rz, input logic rn);
        samples_pending.push_back('{rx[31:0], ry[31:0], rz[31:0], rn});
    endtask

    // mostly plausible rates (about +-4 rad/s), now and then any 32-bit pattern
    function automatic logic signed [31:0] random_rate();
        if ($urandom_range(9, 0) == 0) return $urandom;
        return $signed($urandom_range(134217728, 0)) - 32'sd67108864;
    endfunction

    localparam longint RMAX = 64'sd2147483647;
    localparam longint RMIN = -64'sd2147483648;

    initial begin
        logic [31:0] phase_dt[3];
        att_q = '{longint'(Q_ONE), 0, 0, 0};
        step_dt = DT_RESET;
        send_idle_pct = 13;
        recv_idle_pct = 80;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset step size: identity hold, plain rotations, extreme rates
        queue_sample(0, 0, 0, 0);
        queue_sample(0, 0, 0, 1);
        queue_sample(64'sd16777216, 0, 0, 0);
        queue_sample(0, 64'sd16777216, 0, 1);
        queue_sample(0, 0, -64'sd16777216, 0);
        queue_sample(RMAX, RMAX, RMAX, 0);
        queue_sample(RMIN, RMIN, RMIN, 1);
        queue_sample(RMAX, RMIN, RMAX, 1);
        drain();

        // longest step: components and gravity terms run into saturation
        write_time_step(32'hFFFF_FFFF);
        queue_sample(RMAX, 0, 0, 0);
        queue_sample(RMAX, RMAX, RMIN, 0);
        queue_sample(RMIN, RMAX, RMAX, 0);
        queue_sample(RMIN, RMIN, RMIN, 0);
        queue_sample(RMAX, RMIN, RMAX, 1);
        queue_sample(-1, -1, -1, 1);
        queue_sample(RMIN, RMAX, RMIN, 0);
        drain();

        // zero step: rates add nothing to the attitude; only renormalise can change it
        write_time_step(32'd0);
        queue_sample(RMAX, RMIN, 1, 0);
        queue_sample(RMIN, -1, RMAX, 1);
        queue_sample(64'sd123456, -64'sd654321, 64'sd777, 0);
        drain();

        phase_dt[0] = DT_RESET;
        phase_dt[1] = $urandom_range(32'h0400_0000, 1);
        phase_dt[2] = $urandom;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = ph == 0 ? 13 : ph == 1 ? 80 : 0;
            recv_idle_pct = ph == 0 ? 80 : ph == 1 ? 13 : 0;
            write_time_step(phase_dt[ph]);
            for (int i = 0; i < 470; i++)
                samples_pending.push_back('{random_rate(), random_rate(), random_rate(),
                                            $urandom_range(9, 0) < 4});
            drain();
        end

        if (!failed) begin
            $display("[quaternion_gyro_integrator] OK");
        end else begin
            $display("[quaternion_gyro_integrator] ERROR");
        end
        $finish;
    end
endmodule
